[src/utf8_aware_binary_detector_top_macros.svh]
// Assertion macros shared by the detector RTL.
// Every check samples on the rising edge of clk and is held off while rst is high.
`ifndef UTF8_AWARE_BINARY_DETECTOR_TOP_MACROS_SVH
`define UTF8_AWARE_BINARY_DETECTOR_TOP_MACROS_SVH

// Condition must hold in every cycle out of reset.
`define UABD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define UABD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/uabd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package uabd_pkg;

  // Width of the byte position counters
  localparam int unsigned POS_W = 32;

  // Allowed range of the next continuation byte
  localparam logic [2:0] RANGE_NORMAL = 3'd0;  // 0x80..0xBF
  localparam logic [2:0] RANGE_E0     = 3'd1;  // 0xA0..0xBF
  localparam logic [2:0] RANGE_ED     = 3'd2;  // 0x80..0x9F
  localparam logic [2:0] RANGE_F0     = 3'd3;  // 0x90..0xBF
  localparam logic [2:0] RANGE_F4     = 3'd4;  // 0x80..0x8F

  // Byte values
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] PRINT_LO       = 8'h20;
  localparam logic [7:0] PRINT_HI       = 8'h7E;
  localparam logic [7:0] CONT_LO        = 8'h80;
  localparam logic [7:0] CONT_8F        = 8'h8F;
  localparam logic [7:0] CONT_90        = 8'h90;
  localparam logic [7:0] CONT_9F        = 8'h9F;
  localparam logic [7:0] CONT_A0        = 8'hA0;
  localparam logic [7:0] CONT_HI        = 8'hBF;
  localparam logic [7:0] LEAD2_LO       = 8'hC2;
  localparam logic [7:0] LEAD2_HI       = 8'hDF;
  localparam logic [7:0] LEAD3_E0       = 8'hE0;
  localparam logic [7:0] LEAD3_ED       = 8'hED;
  localparam logic [7:0] LEAD3_HI       = 8'hEF;
  localparam logic [7:0] LEAD4_F0       = 8'hF0;
  localparam logic [7:0] LEAD4_F4       = 8'hF4;

  // Check a continuation byte against its range class
  function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] cls);
    logic ok;
    unique case (cls)
      RANGE_E0: ok = (b >= CONT_A0) && (b <= CONT_HI);
      RANGE_ED: ok = (b >= CONT_LO) && (b <= CONT_9F);
      RANGE_F0: ok = (b >= CONT_90) && (b <= CONT_HI);
      RANGE_F4: ok = (b >= CONT_LO) && (b <= CONT_8F);
      default:  ok = (b >= CONT_LO) && (b <= CONT_HI);
    endcase
    return ok;
  endfunction

  // Number of continuation bytes a lead byte opens, zero if not a lead
  function automatic logic [1:0] lead_len(input logic [7:0] b);
    logic [1:0] n;
    priority if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) n = 2'd1;
    else if ((b >= LEAD3_E0) && (b <= LEAD3_HI))     n = 2'd2;
    else if ((b >= LEAD4_F0) && (b <= LEAD4_F4))     n = 2'd3;
    else                                             n = 2'd0;
    return n;
  endfunction

  // Range class of the first continuation byte after a lead
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] c;
    priority if (b == LEAD3_E0) c = RANGE_E0;
    else if (b == LEAD3_ED)     c = RANGE_ED;
    else if (b == LEAD4_F0)     c = RANGE_F0;
    else if (b == LEAD4_F4)     c = RANGE_F4;
    else                        c = RANGE_NORMAL;
    return c;
  endfunction

endpackage

`default_nettype wire

[src/utf8_aware_binary_detector_top.sv]
// Text/binary detector with UTF-8 awareness.
// Input channel s_*: one byte of the buffer per transfer, s_tlast on the
// final byte. Byte 0 of each buffer is not checked; later bytes must be CR,
// LF, printable ASCII or part of a strictly valid UTF-8 sequence.
// Output channel m_*: one result transfer per buffer, carrying the binary
// flag and the index of the first offending byte or sequence lead (zero
// for text).
// Throughput: one byte per cycle while no result is held back by a stalled receiver.
// The result is registered: m_tvalid rises in the cycle after the last byte's transfer.
// The result sits in an output register; while it waits, s_tready stays
// high only if m_tready is high, so a stalled receiver holds off new bytes
// and nothing is lost.
// After each result the position counter and UTF-8 state return to zero,
// ready for the next buffer.
// Reset (rst, synchronous) clears the state and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_aware_binary_detector_top_macros.svh"

module utf8_aware_binary_detector_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [0] is_binary, [32:1] binary_position, [39:33] zero
);
  import uabd_pkg::*;

  logic [POS_W-1:0] byte_index, byte_index_next;
  logic [1:0]       cont_left, cont_left_next;
  logic [2:0]       range_cls, range_cls_next;
  logic [POS_W-1:0] seq_start, seq_start_next;
  logic             found, found_next;
  logic [POS_W-1:0] found_pos, found_pos_next;
  logic             out_binary;
  logic [31:0]      out_pos;
  logic             res_binary;
  logic [POS_W-1:0] res_pos;
  logic             in_xfer;
  logic             is_plain;
  logic [1:0]       lead_n;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, out_pos, out_binary};

  assign is_plain = (s_tdata == BYTE_CR) || (s_tdata == BYTE_LF) ||
                    ((s_tdata >= PRINT_LO) && (s_tdata <= PRINT_HI));
  assign lead_n   = lead_len(s_tdata);

  // Check one byte and advance the sequence state
  always_comb begin
    cont_left_next = cont_left;
    range_cls_next = range_cls;
    seq_start_next = seq_start;
    found_next     = found;
    found_pos_next = found_pos;
    if (!found && (byte_index != '0)) begin
      if (cont_left != 2'd0) begin
        if (cont_ok(s_tdata, range_cls)) begin
          cont_left_next = cont_left - 2'd1;
          range_cls_next = RANGE_NORMAL;
        end else begin
          found_next     = 1'b1;
          found_pos_next = seq_start;
          cont_left_next = 2'd0;
          range_cls_next = RANGE_NORMAL;
        end
      end else if (!is_plain) begin
        if (lead_n != 2'd0) begin
          cont_left_next = lead_n;
          range_cls_next = lead_class(s_tdata);
          seq_start_next = byte_index;
        end else begin
          found_next     = 1'b1;
          found_pos_next = byte_index;
        end
      end
    end
    // Saturate the position counter
    byte_index_next = (byte_index != '1) ? byte_index + 1'b1 : byte_index;
    // Close the buffer: an open sequence counts as binary at its lead
    res_binary = found_next || (cont_left_next != 2'd0);
    if (found_next) begin
      res_pos = found_pos_next;
    end else if (cont_left_next != 2'd0) begin
      res_pos = seq_start_next;
    end else begin
      res_pos = '0;
    end
  end

  // Update state on each byte transfer; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      cont_left  <= 2'd0;
      range_cls  <= RANGE_NORMAL;
      seq_start  <= '0;
      found      <= 1'b0;
      found_pos  <= '0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        byte_index <= '0;
        cont_left  <= 2'd0;
        range_cls  <= RANGE_NORMAL;
        seq_start  <= '0;
        found      <= 1'b0;
        found_pos  <= '0;
      end else begin
        byte_index <= byte_index_next;
        cont_left  <= cont_left_next;
        range_cls  <= range_cls_next;
        seq_start  <= seq_start_next;
        found      <= found_next;
        found_pos  <= found_pos_next;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      out_binary <= res_binary;
      out_pos    <= 32'(res_pos);
    end
  end

  `UABD_ASSERT_ALWAYS(a_open_seq_not_found, (cont_left == 2'd0) || !found,
                      "open UTF-8 sequence after binary was found")
  `UABD_ASSERT_ALWAYS(a_found_pos_bound, !found || ((found_pos <= byte_index) &&
                      (byte_index != '0)), "found position beyond byte index")
  `UABD_ASSERT_ALWAYS(a_seq_start_bound, (cont_left == 2'd0) ||
                      (seq_start < byte_index) || (byte_index == '1),
                      "sequence start not before byte index")
  `UABD_ASSERT_NEXT(a_last_clears, in_xfer && s_tlast,
                    m_tvalid && (byte_index == '0) && !found && (cont_left == 2'd0),
                    "state not cleared after last byte")
  `UABD_ASSERT_ALWAYS(a_text_pos_zero, !m_tvalid || m_tdata[0] || (m_tdata[32:1] == 32'd0),
                      "text result with nonzero position")

endmodule

`default_nettype wire

[sim/utf8_aware_binary_detector_top_tb.sv]
`timescale 1ns / 1ps

module utf8_aware_binary_detector_top_tb;
  import uabd_pkg::*;

  typedef struct packed {
    logic        flag;
    logic [31:0] pos;
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   want;
  } plan_row_t;

  localparam int PLAN_LEN = 30;
  localparam int RANDOM_BYTES = 1600;

  // Directed buffers; typed rows carry their verdict, the rest use the predictor
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // single-byte buffer: index 0 is never checked
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 32'd0}},
    // tab is binary
    '{8'h41, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h09, 1'b1, 1'b1, '{1'b1, 32'd1}},
    // NUL at index 0 passes, DEL does not
    '{8'h00, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h7F, 1'b1, 1'b1, '{1'b1, 32'd1}},
    // printable extremes and the highest 4-byte lead
    '{8'h20, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h7E, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hF4, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h8F, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hBF, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h80, 1'b1, 1'b0, '{1'b0, 32'd0}},
    // lowest 4-byte lead with its narrow second byte
    '{8'h0D, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hF0, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h90, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hBF, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h80, 1'b1, 1'b0, '{1'b0, 32'd0}},
    // overlong 3-byte form: continuation out of range
    '{8'h41, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hE0, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h9F, 1'b1, 1'b0, '{1'b0, 32'd0}},
    // CR/LF then a surrogate
    '{8'h0A, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h0D, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h0A, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hED, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hA0, 1'b1, 1'b0, '{1'b0, 32'd0}},
    // sequence cut off by the end of the buffer
    '{8'h41, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'hC2, 1'b1, 1'b1, '{1'b1, 32'd1}},
    // stray continuation, later bytes unchecked
    '{8'h41, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h80, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b0, '{1'b0, 32'd0}},
    '{8'h7E, 1'b1, 1'b1, '{1'b1, 32'd1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [0] is_binary, [32:1] binary_position, [39:33] zero

  // Predictor state
  logic [POS_W-1:0] byte_idx;
  logic [POS_W-1:0] lead_idx;
  logic [POS_W-1:0] fail_idx;
  logic [1:0]       cont_due;
  logic [2:0]       cont_class;
  logic             failed;

  verdict_t pending_verdicts [$];
  verdict_t head;
  logic [7:0] frame_bytes [$];
  int errors = 0;
  int bytes_sent = 0;
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;
  int rx_gap;

  utf8_aware_binary_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_predictor();
    byte_idx   = '0;
    lead_idx   = '0;
    fail_idx   = '0;
    cont_due   = 2'd0;
    cont_class = RANGE_NORMAL;
    failed     = 1'b0;
  endtask

  task automatic flag_fail(input logic [POS_W-1:0] where);
    failed     = 1'b1;
    fail_idx   = where;
    cont_due   = 2'd0;
    cont_class = RANGE_NORMAL;
  endtask

  // Advance the predictor by one byte; return a verdict on the last byte
  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output logic done, output verdict_t v);
    logic [1:0] n;
    logic [2:0] cls;
    logic [7:0] lo;
    logic [7:0] hi;
    done = 1'b0;
    v = '0;
    if (!failed && byte_idx != '0) begin
      if (cont_due != 2'd0) begin
        // check a continuation byte against its window
        case (cont_class)
          RANGE_E0: begin lo = CONT_A0; hi = CONT_HI; end
          RANGE_ED: begin lo = CONT_LO; hi = CONT_9F; end
          RANGE_F0: begin lo = CONT_90; hi = CONT_HI; end
          RANGE_F4: begin lo = CONT_LO; hi = CONT_8F; end
          default:  begin lo = CONT_LO; hi = CONT_HI; end
        endcase
        if (b >= lo && b <= hi) begin
          cont_due   = cont_due - 2'd1;
          cont_class = RANGE_NORMAL;
        end else begin
          flag_fail(lead_idx);
        end
      end else if (!(b == BYTE_CR || b == BYTE_LF || (b >= PRINT_LO && b <= PRINT_HI))) begin
        // decode a lead byte
        n = 2'd0;
        cls = RANGE_NORMAL;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          n = 2'd1;
        end else if (b >= LEAD3_E0 && b <= LEAD3_HI) begin
          n = 2'd2;
          if (b == LEAD3_E0) cls = RANGE_E0;
          else if (b == LEAD3_ED) cls = RANGE_ED;
        end else if (b >= LEAD4_F0 && b <= LEAD4_F4) begin
          n = 2'd3;
          if (b == LEAD4_F0) cls = RANGE_F0;
          else if (b == LEAD4_F4) cls = RANGE_F4;
        end
        if (n != 2'd0) begin
          cont_due   = n;
          cont_class = cls;
          lead_idx   = byte_idx;
        end else begin
          flag_fail(byte_idx);
        end
      end
    end
    // saturate instead of wrapping
    if (byte_idx != '1) byte_idx = byte_idx + 1'b1;
    if (last) begin
      if (!failed && cont_due != 2'd0) flag_fail(lead_idx);
      done   = 1'b1;
      v.flag = failed;
      v.pos  = failed ? 32'(fail_idx) : 32'd0;
      clear_predictor();
    end
  endtask

  // Send one byte after a random gap and record its verdict
  task automatic feed(input logic [7:0] b, input logic last,
                      input logic typed, input verdict_t typed_v);
    int gap;
    logic done;
    verdict_t v;
    gap = calm_tx ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b, last, done, v);
    if (done) pending_verdicts.push_back(typed ? typed_v : v);
    bytes_sent++;
  endtask

  // Pick a continuation byte, sometimes from the full window to hit near misses
  function automatic logic [7:0] pick_cont(input logic [2:0] cls);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h80, 8'hBF));
    case (cls)
      RANGE_E0: return 8'($urandom_range(8'hA0, 8'hBF));
      RANGE_ED: return 8'($urandom_range(8'h80, 8'h9F));
      RANGE_F0: return 8'($urandom_range(8'h90, 8'hBF));
      RANGE_F4: return 8'($urandom_range(8'h80, 8'h8F));
      default:  return 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  // Append one text token: a control, an ASCII byte or a UTF-8 sequence
  task automatic append_token();
    logic [7:0] lead;
    logic [2:0] cls;
    cls = RANGE_NORMAL;
    case ($urandom_range(0, 7))
      0: frame_bytes.push_back(BYTE_CR);
      1: frame_bytes.push_back(BYTE_LF);
      2, 3: frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      4: begin
        frame_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        frame_bytes.push_back(pick_cont(RANGE_NORMAL));
      end
      5: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        if (lead == LEAD3_E0) cls = RANGE_E0;
        else if (lead == LEAD3_ED) cls = RANGE_ED;
        frame_bytes.push_back(lead);
        frame_bytes.push_back(pick_cont(cls));
        frame_bytes.push_back(pick_cont(RANGE_NORMAL));
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        if (lead == LEAD4_F0) cls = RANGE_F0;
        else if (lead == LEAD4_F4) cls = RANGE_F4;
        frame_bytes.push_back(lead);
        frame_bytes.push_back(pick_cont(cls));
        frame_bytes.push_back(pick_cont(RANGE_NORMAL));
        frame_bytes.push_back(pick_cont(RANGE_NORMAL));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want_v);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want_v);
    errors++;
  endtask

  // Compare each result transfer with the oldest verdict
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 40'd0);
      end else begin
        head = pending_verdicts.pop_front();
        if (m_tdata[0] !== head.flag)
          report_mismatch("is_binary", {39'd0, m_tdata[0]}, {39'd0, head.flag});
        if (m_tdata[32:1] !== head.pos)
          report_mismatch("binary_position", {8'd0, m_tdata[32:1]}, {8'd0, head.pos});
        if (m_tdata[39:33] !== 7'd0)
          report_mismatch("pad bits", {33'd0, m_tdata[39:33]}, 40'd0);
      end
    end
  end

  // Receiver: random stall before each result, with calm stretches
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm_rx = ~calm_rx;
      rx_gap = calm_rx ? 0 : $urandom_range(0, 10);
      if (rx_gap != 0) begin
        m_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int kind;
    int tokens;
    int pick;
    clear_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed buffers
    for (int i = 0; i < PLAN_LEN; i++) begin
      feed(PLAN[i].data, PLAN[i].last, PLAN[i].typed, PLAN[i].want);
    end

    // random buffers: mostly well-formed text, some corrupted, some noise
    while (bytes_sent < PLAN_LEN + RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) calm_tx = ~calm_tx;
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      kind = $urandom_range(0, 9);
      tokens = $urandom_range(0, 12);
      if (kind < 7) begin
        repeat (tokens) append_token();
        // overwrite one checked byte
        if (kind == 5 && frame_bytes.size() > 1) begin
          pick = $urandom_range(1, frame_bytes.size() - 1);
          frame_bytes[pick] = 8'($urandom_range(0, 255));
        end
        // cut the tail, likely splitting a sequence
        if (kind == 6) begin
          repeat ($urandom_range(1, 3)) begin
            if (frame_bytes.size() > 1) void'(frame_bytes.pop_back());
          end
        end
      end else begin
        repeat (tokens) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      foreach (frame_bytes[i]) begin
        feed(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    // drain outstanding results, then hold off for the output register
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
